[hw/rtl/mmdf_pkg.sv]
// ----------------------------------------------------------------------------
// mmdf_pkg
// Shared constants for the moving mean deadband filter: field widths,
// register indexes and reset values.
// ----------------------------------------------------------------------------
package mmdf_pkg;

    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int SAMPLE_BITS_DEF  = 16;

    localparam int THR_BITS      = 16;
    localparam int THR_FRAC_BITS = 16;
    localparam int WLEN_BITS     = 7;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_REL_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH = 2'd1;

    localparam logic [THR_BITS-1:0]  REL_THRESHOLD_RST = 16'd3277;
    localparam logic [WLEN_BITS-1:0] WINDOW_LENGTH_RST = 7'd16;

endpackage

[hw/rtl/moving_mean_deadband_filter_unit.sv]
// ----------------------------------------------------------------------------
// moving_mean_deadband_filter_unit
// Relative deadband filter: flags a sample that lies within a Q0.16
// fraction of the mean of the previous window of samples.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   sample
//   out      output     out_valid / out_stall suppress
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one word per cycle sustained while out_stall is low; path to the result:
// input register, one pass of window update and compare, result register
// in_stall rises only when both the input and result registers are full
// reset empties the window and loads threshold 3277 and window length 16
// a window length write empties the window; cfg_ready is always high
// ----------------------------------------------------------------------------
module moving_mean_deadband_filter_unit
    import mmdf_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          suppress,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

    localparam int SLOT_BITS = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_BITS  = SAMPLE_BITS + SLOT_BITS;

    logic [THR_BITS-1:0]           thr_reg;
    logic [WLEN_BITS-1:0]          wlen_reg;
    logic                          cfg_fire;
    logic                          clear;

    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                          res_valid_reg;
    logic                          suppress_reg;

    logic                          res_load;
    logic                          s1_advance;
    logic                          in_fire;

    logic signed [SUM_BITS-1:0]    win_sum;
    logic [CNT_BITS-1:0]           win_fill;
    logic                          flag;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign clear     = cfg_fire && (cfg_index == CFG_WINDOW_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= REL_THRESHOLD_RST;
            wlen_reg <= WINDOW_LENGTH_RST;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                CFG_REL_THRESHOLD: thr_reg  <= cfg_data[THR_BITS-1:0];
                CFG_WINDOW_LENGTH: wlen_reg <= cfg_data[WLEN_BITS-1:0];
                default:           ;
            endcase
        end
    end

    assign res_load   = !res_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && res_load;
    assign in_stall   = s1_valid_reg && !res_load;
    assign in_fire    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire || s1_advance)
            begin
                s1_valid_reg <= in_fire;
            end
            if (res_load)
            begin
                res_valid_reg <= s1_advance;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_sample_reg <= sample;
        end
        if (s1_advance)
        begin
            suppress_reg <= flag;
        end
    end

    mmdf_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .clear         (clear),
        .window_length (wlen_reg),
        .push          (s1_advance),
        .sample        (s1_sample_reg),
        .sum           (win_sum),
        .fill          (win_fill)
    );

    mmdf_decide #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_decide (
        .sample        (s1_sample_reg),
        .sum           (win_sum),
        .fill          (win_fill),
        .rel_threshold (thr_reg),
        .suppress      (flag)
    );

    assign out_valid = res_valid_reg;
    assign suppress  = suppress_reg;

    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && res_valid_reg)
        else $error("input stalled with free pipeline slot");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && out_stall |=> res_valid_reg && $stable(suppress_reg))
        else $error("stalled result lost");

    a_advance_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> res_valid_reg)
        else $error("advanced word missing from result register");

endmodule

[hw/rtl/mmdf_window.sv]
// ----------------------------------------------------------------------------
// mmdf_window
// Sample ring, running sum, fill count and write slot. The ring entry that
// the next word will retire is read ahead into a register, with a bypass
// for a one-entry window.
// ----------------------------------------------------------------------------
module mmdf_window
    import mmdf_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    localparam int SLOT_BITS   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
    localparam int CNT_BITS    = $clog2(WINDOW_DEPTH + 1),
    localparam int SUM_BITS    = SAMPLE_BITS + SLOT_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic [WLEN_BITS-1:0]          window_length,
    input  logic                          push,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [SUM_BITS-1:0]    sum,
    output logic [CNT_BITS-1:0]           fill
);

    logic signed [SAMPLE_BITS-1:0] ring_mem [WINDOW_DEPTH];
    logic signed [SAMPLE_BITS-1:0] oldest_reg;

    logic signed [SUM_BITS-1:0] sum_reg;
    logic signed [SUM_BITS-1:0] sum_next;
    logic [CNT_BITS-1:0]        fill_reg;
    logic [CNT_BITS-1:0]        fill_next;
    logic [SLOT_BITS-1:0]       slot_reg;
    logic [SLOT_BITS-1:0]       slot_next;

    logic [CNT_BITS-1:0]        len_eff;
    logic [SLOT_BITS:0]         slot_inc;
    logic                       full;

    always_comb
    begin
        if (window_length == '0)
        begin
            len_eff = CNT_BITS'(1);
        end
        else if (32'(window_length) > WINDOW_DEPTH)
        begin
            len_eff = CNT_BITS'(WINDOW_DEPTH);
        end
        else
        begin
            len_eff = CNT_BITS'(window_length);
        end
    end

    assign full     = 32'(fill_reg) >= 32'(len_eff);
    assign slot_inc = {1'b0, slot_reg} + (SLOT_BITS+1)'(1);

    always_comb
    begin
        sum_next  = sum_reg;
        fill_next = fill_reg;
        slot_next = slot_reg;
        if (clear)
        begin
            sum_next  = '0;
            fill_next = '0;
            slot_next = '0;
        end
        else if (push)
        begin
            if (full)
            begin
                sum_next = sum_reg - SUM_BITS'(oldest_reg) + SUM_BITS'(sample);
            end
            else
            begin
                sum_next  = sum_reg + SUM_BITS'(sample);
                fill_next = fill_reg + CNT_BITS'(1);
            end
            if (32'(slot_inc) >= 32'(len_eff))
            begin
                slot_next = '0;
            end
            else
            begin
                slot_next = slot_inc[SLOT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            fill_reg <= '0;
            slot_reg <= '0;
        end
        else
        begin
            sum_reg  <= sum_next;
            fill_reg <= fill_next;
            slot_reg <= slot_next;
        end
    end

    // ring write and read-ahead of the entry at the next slot
    always_ff @(posedge clk)
    begin
        if (push && !clear)
        begin
            ring_mem[slot_reg] <= sample;
        end
        if (push && !clear && (slot_reg == slot_next))
        begin
            oldest_reg <= sample;
        end
        else
        begin
            oldest_reg <= ring_mem[slot_next];
        end
    end

    assign sum  = sum_reg;
    assign fill = fill_reg;

    a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= 32'(len_eff))
        else $error("fill count beyond window length");

    a_slot_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        32'(slot_reg) < 32'(len_eff))
        else $error("write slot beyond window length");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (fill_reg == '0) && (sum_reg == '0))
        else $error("window not emptied after clear");

    a_empty_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> (sum_reg == '0))
        else $error("nonzero sum in empty window");

endmodule

[hw/rtl/mmdf_decide.sv]
// ----------------------------------------------------------------------------
// mmdf_decide
// Cross-multiplied deadband test of one sample against the window mean:
// |sum - sample*fill| * 2^16 <= threshold * sum; negative sum always flags.
// ----------------------------------------------------------------------------
module mmdf_decide
    import mmdf_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    localparam int SLOT_BITS   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
    localparam int CNT_BITS    = $clog2(WINDOW_DEPTH + 1),
    localparam int SUM_BITS    = SAMPLE_BITS + SLOT_BITS,
    localparam int DIFF_BITS   = SAMPLE_BITS + CNT_BITS + 1,
    localparam int CMP_BITS    = DIFF_BITS + THR_FRAC_BITS
)
(
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic signed [SUM_BITS-1:0]    sum,
    input  logic [CNT_BITS-1:0]           fill,
    input  logic [THR_BITS-1:0]           rel_threshold,
    output logic                          suppress
);

    logic signed [DIFF_BITS-1:0]      prod_xc;
    logic signed [DIFF_BITS-1:0]      diff;
    logic [DIFF_BITS-1:0]             mag;
    logic [CMP_BITS-1:0]              lhs;
    logic [THR_BITS+SUM_BITS-2:0]     rhs;

    assign prod_xc = DIFF_BITS'(sample) * DIFF_BITS'($signed({1'b0, fill}));
    assign diff    = DIFF_BITS'(sum) - prod_xc;
    assign mag     = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
    assign lhs     = {mag, {THR_FRAC_BITS{1'b0}}};
    assign rhs     = rel_threshold * sum[SUM_BITS-2:0];

    always_comb
    begin
        if ((fill == '0) || (sum == '0))
        begin
            suppress = 1'b0;
        end
        else if (sum[SUM_BITS-1])
        begin
            suppress = 1'b1;
        end
        else
        begin
            suppress = lhs <= CMP_BITS'(rhs);
        end
    end

endmodule
